FILE: hw/rtl/mm_pkg.sv
// Shared constants, command type and dimension helper for the matrix multiplier.
package mm_pkg;

    localparam int MAX_DIM_DEF   = 8;
    localparam int ELEM_BITS_DEF = 16;

    localparam int CFG_W     = 4;
    localparam int CFG_IDX_W = 2;
    localparam int IDX_W     = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INNER_DIM = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_B    = 2'd2;

    localparam logic [CFG_W-1:0] DIM_RESET = 4'd4;

    typedef struct packed {
        logic             load_a;
        logic             load_b;
        logic             issue;
        logic             first;
        logic             last;
        logic             last_elem;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
    } t_cmd;

    // Zero acts as one, anything above the maximum saturates.
    function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] v,
                                                   input logic [CFG_W-1:0] max_dim);
        logic [CFG_W-1:0] d;
        if (v == '0) begin
            d = CFG_W'(1);
        end else if (v > max_dim) begin
            d = max_dim;
        end else begin
            d = v;
        end
        return d;
    endfunction

endpackage

FILE: hw/rtl/matrix_multiply.sv
// Top level of the fixed-point matrix multiplier C = A x B.
//
//   channel   direction  handshake                   payload
//   -------   ---------  --------------------------  ------------------------------------
//   in        to block   i_in_valid / o_in_ready     i_element_value (A then B, row-major)
//   out       from block o_out_valid / i_out_ready   o_product_value, o_row_index,
//                                                    o_col_index, o_last_element
//   cfg       to block   i_cfg_we (no wait)          i_cfg_index, i_cfg_data
//
// Loading takes one item per cycle. Once the last B item is in, one shared
// multiplier runs rows*inner*cols multiply-accumulates, one per cycle while the
// output does not stall, and results leave in row-major order.
// Reset (synchronous, active low) sets all dimensions to 4 and empties the pipe.
// A stalled output freezes the multiply pipeline at the sum that cannot leave;
// no item is taken while products are being issued.
module matrix_multiply
    import mm_pkg::*;
#(
    parameter int MAX_DIM   = MAX_DIM_DEF,
    parameter int ELEM_BITS = ELEM_BITS_DEF,
    localparam int DEPTH    = MAX_DIM * MAX_DIM,
    localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int OUT_W    = 2 * ELEM_BITS + 3
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [ELEM_BITS-1:0] i_element_value,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [OUT_W-1:0]     o_product_value,
    output logic [IDX_W-1:0]     o_row_index,
    output logic [IDX_W-1:0]     o_col_index,
    output logic                 o_last_element
);

    // Command from the sequencer, stall back from the result register.
    t_cmd              w_cmd;
    logic              w_stall;
    logic [ADDR_W-1:0] w_ld_addr, w_rd_a_addr, w_rd_b_addr;

    mm_ctrl #(
        .MAX_DIM (MAX_DIM)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_stall     (w_stall),
        .o_cmd       (w_cmd),
        .o_ld_addr   (w_ld_addr),
        .o_rd_a_addr (w_rd_a_addr),
        .o_rd_b_addr (w_rd_b_addr)
    );

    // Operands are read one address per side per cycle unless stalled; sums collect in one accumulator.
    mm_dpath #(
        .MAX_DIM   (MAX_DIM),
        .ELEM_BITS (ELEM_BITS)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_ld_addr       (w_ld_addr),
        .i_rd_a_addr     (w_rd_a_addr),
        .i_rd_b_addr     (w_rd_b_addr),
        .i_element_value (i_element_value),
        .o_stall         (w_stall),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_product_value (o_product_value),
        .o_row_index     (o_row_index),
        .o_col_index     (o_col_index),
        .o_last_element  (o_last_element)
    );

`ifndef SYNTHESIS
    // The pipe may freeze only behind a full, unread result register.
    a_stall_needs_full_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stall |-> (o_out_valid && !i_out_ready))
        else $error("pipeline stalled with room in the result register");

    // Products are never issued while new items may overwrite the operands.
    a_no_issue_while_loading: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.issue |-> !o_in_ready)
        else $error("multiply issued while input is open");

    // The compute phase starts only right after an item of B was stored.
    a_run_after_b_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_in_ready) |-> $past(w_cmd.load_b))
        else $error("compute started without completing B");
`endif

endmodule

FILE: hw/rtl/mm_ctrl.sv
// Controller: configuration registers, load counter and multiply-accumulate sequencer.
module mm_ctrl
    import mm_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF,
    localparam int DEPTH  = MAX_DIM * MAX_DIM,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_stall,
    output t_cmd                 o_cmd,
    output logic [ADDR_W-1:0]    o_ld_addr,
    output logic [ADDR_W-1:0]    o_rd_a_addr,
    output logic [ADDR_W-1:0]    o_rd_b_addr
);

    localparam int CNT_W = $clog2(2 * DEPTH);
    localparam int TW    = CNT_W + 1;

    typedef enum logic [1:0] {
        S_LOAD = 2'b01,
        S_RUN  = 2'b10
    } t_state;

    t_state            r_state, n_state;
    logic [CFG_W-1:0]  r_rows, n_rows, r_inner, n_inner, r_cols, n_cols;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [CFG_W-1:0]  r_i, n_i, r_j, n_j, r_k, n_k;
    logic [ADDR_W-1:0] r_a_row, n_a_row, r_a_addr, n_a_addr, r_b_addr, n_b_addr;

    logic [CFG_W-1:0] w_rows_c, w_inner_c, w_cols_c;
    logic [TW-1:0]    w_total_a, w_total, w_count_ext, w_b_off;
    logic             w_accept, w_in_a, w_load_done, w_issue;
    logic             w_k_last, w_j_last, w_i_last;

    assign w_rows_c  = clamp_dim(r_rows,  CFG_W'(MAX_DIM));
    assign w_inner_c = clamp_dim(r_inner, CFG_W'(MAX_DIM));
    assign w_cols_c  = clamp_dim(r_cols,  CFG_W'(MAX_DIM));

    assign w_total_a   = TW'(w_rows_c) * TW'(w_inner_c);
    assign w_total     = w_total_a + TW'(w_inner_c) * TW'(w_cols_c);
    assign w_count_ext = {1'b0, r_count};
    assign w_b_off     = w_count_ext - w_total_a;

    assign o_in_ready  = (r_state == S_LOAD);
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_in_a      = (w_count_ext < w_total_a);
    assign w_load_done = w_accept && (w_count_ext == w_total - TW'(1));
    assign o_ld_addr   = w_in_a ? r_count[ADDR_W-1:0] : w_b_off[ADDR_W-1:0];

    assign w_issue  = (r_state == S_RUN) && !i_stall;
    assign w_k_last = (r_k == w_inner_c - CFG_W'(1));
    assign w_j_last = (r_j == w_cols_c - CFG_W'(1));
    assign w_i_last = (r_i == w_rows_c - CFG_W'(1));

    assign o_rd_a_addr = r_a_addr;
    assign o_rd_b_addr = r_b_addr;

    always_comb begin
        o_cmd.load_a    = w_accept && w_in_a;
        o_cmd.load_b    = w_accept && !w_in_a;
        o_cmd.issue     = w_issue;
        o_cmd.first     = (r_k == '0);
        o_cmd.last      = w_k_last;
        o_cmd.last_elem = w_i_last && w_j_last;
        o_cmd.row       = r_i[IDX_W-1:0];
        o_cmd.col       = r_j[IDX_W-1:0];
    end

    always_comb begin
        n_state  = r_state;
        n_rows   = r_rows;
        n_inner  = r_inner;
        n_cols   = r_cols;
        n_count  = r_count;
        n_i      = r_i;
        n_j      = r_j;
        n_k      = r_k;
        n_a_row  = r_a_row;
        n_a_addr = r_a_addr;
        n_b_addr = r_b_addr;
        case (r_state)
            S_LOAD: begin
                if (w_load_done) begin
                    n_count  = '0;
                    n_state  = S_RUN;
                    n_i      = '0;
                    n_j      = '0;
                    n_k      = '0;
                    n_a_row  = '0;
                    n_a_addr = '0;
                    n_b_addr = '0;
                end else if (w_accept) begin
                    n_count = r_count + CNT_W'(1);
                end
            end
            S_RUN: begin
                if (w_issue) begin
                    if (!w_k_last) begin
                        n_k      = r_k + CFG_W'(1);
                        n_a_addr = r_a_addr + ADDR_W'(1);
                        n_b_addr = r_b_addr + ADDR_W'(w_cols_c);
                    end else begin
                        n_k = '0;
                        if (!w_j_last) begin
                            n_j      = r_j + CFG_W'(1);
                            n_a_addr = r_a_row;
                            n_b_addr = ADDR_W'(r_j + CFG_W'(1));
                        end else begin
                            n_j      = '0;
                            n_b_addr = '0;
                            n_a_row  = r_a_row + ADDR_W'(w_inner_c);
                            n_a_addr = r_a_row + ADDR_W'(w_inner_c);
                            if (w_i_last) begin
                                n_i     = '0;
                                n_state = S_LOAD;
                            end else begin
                                n_i = r_i + CFG_W'(1);
                            end
                        end
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
        // Any register write drops a partial load.
        if (i_cfg_we) begin
            n_count = '0;
            case (i_cfg_index)
                CFG_ROWS_A:    n_rows  = i_cfg_data;
                CFG_INNER_DIM: n_inner = i_cfg_data;
                CFG_COLS_B:    n_cols  = i_cfg_data;
                default:       ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_rows  <= DIM_RESET;
            r_inner <= DIM_RESET;
            r_cols  <= DIM_RESET;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_rows  <= n_rows;
            r_inner <= n_inner;
            r_cols  <= n_cols;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i      <= n_i;
        r_j      <= n_j;
        r_k      <= n_k;
        r_a_row  <= n_a_row;
        r_a_addr <= n_a_addr;
        r_b_addr <= n_b_addr;
    end

endmodule

FILE: hw/rtl/mm_dpath.sv
// Datapath: operand memories, multiplier, accumulator and result register.
module mm_dpath
    import mm_pkg::*;
#(
    parameter int MAX_DIM   = MAX_DIM_DEF,
    parameter int ELEM_BITS = ELEM_BITS_DEF,
    localparam int DEPTH    = MAX_DIM * MAX_DIM,
    localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int PROD_W   = 2 * ELEM_BITS,
    localparam int OUT_W    = 2 * ELEM_BITS + 3
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    input  logic [ADDR_W-1:0]    i_ld_addr,
    input  logic [ADDR_W-1:0]    i_rd_a_addr,
    input  logic [ADDR_W-1:0]    i_rd_b_addr,
    input  logic [ELEM_BITS-1:0] i_element_value,
    output logic                 o_stall,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [OUT_W-1:0]     o_product_value,
    output logic [IDX_W-1:0]     o_row_index,
    output logic [IDX_W-1:0]     o_col_index,
    output logic                 o_last_element
);

    logic [ELEM_BITS-1:0] r_left_mem  [DEPTH];
    logic [ELEM_BITS-1:0] r_right_mem [DEPTH];

    logic signed [ELEM_BITS-1:0] r_a_data, r_b_data;
    logic signed [PROD_W-1:0]    r_prod;
    logic [OUT_W-1:0]            r_acc, w_sum;
    t_cmd                        r_s1_cmd, r_s2_cmd;
    logic                        r_out_valid;
    logic [OUT_W-1:0]            r_out_value;
    logic [IDX_W-1:0]            r_out_row, r_out_col;
    logic                        r_out_last;
    logic                        w_stall, w_finish;

    // Freeze the pipe only when a finished sum has nowhere to go.
    assign w_stall  = r_s2_cmd.issue && r_s2_cmd.last && r_out_valid && !i_out_ready;
    assign w_finish = !w_stall && r_s2_cmd.issue && r_s2_cmd.last;
    assign o_stall  = w_stall;

    assign w_sum = (r_s2_cmd.first ? '0 : r_acc) + {{3{r_prod[PROD_W-1]}}, r_prod};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_a) begin
            r_left_mem[i_ld_addr] <= i_element_value;
        end
        if (!w_stall) begin
            r_a_data <= r_left_mem[i_rd_a_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_b) begin
            r_right_mem[i_ld_addr] <= i_element_value;
        end
        if (!w_stall) begin
            r_b_data <= r_right_mem[i_rd_b_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_cmd    <= '0;
            r_s2_cmd    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (!w_stall) begin
                r_s1_cmd <= i_cmd;
                r_s2_cmd <= r_s1_cmd;
            end
            if (w_finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!w_stall) begin
            r_prod <= r_a_data * r_b_data;
        end
        if (!w_stall && r_s2_cmd.issue) begin
            r_acc <= w_sum;
        end
        if (w_finish) begin
            r_out_value <= w_sum;
            r_out_row   <= r_s2_cmd.row;
            r_out_col   <= r_s2_cmd.col;
            r_out_last  <= r_s2_cmd.last_elem;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_product_value = r_out_value;
    assign o_row_index     = r_out_row;
    assign o_col_index     = r_out_col;
    assign o_last_element  = r_out_last;

endmodule
